// ----- hdl/wbce_pkg.sv -----
// ----------------------------------------------------------------------------
// wbce_pkg
// Shared types and constants of the weighted BCE loss accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package wbce_pkg;

    // Default sizes of the top-level parameters
    localparam int COUNT_BITS_DEF = 32;
    localparam int LOG_BITS_DEF   = 10;

    // Fixed field widths and the queue depth
    localparam int PROB_W      = 17;
    localparam int LOSS_W      = 40;
    localparam int SUM_W       = 56;
    localparam int MAG_W       = 21;
    localparam int ADDR_W      = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [PROB_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [PROB_W-1:0] HALF_Q16 = 17'h08000;
    localparam logic [15:0]       LN2_Q16  = 16'd45426;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_BALANCE = 2'd0;
    localparam logic [1:0] REG_BATCH   = 2'd1;
    localparam logic [1:0] REG_FLOOR   = 2'd2;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              target_bit;
        logic              final_item;
    } t_in_item;

    typedef struct packed {
        logic [LOSS_W-1:0] loss_value;
        logic              saturated;
    } t_out_item;

    // Classified item as queued between front and back
    typedef struct packed {
        logic [PROB_W-1:0] q;
        logic              target_bit;
        logic              final_item;
        logic              log_zero;
    } t_queue_item;

    typedef struct packed {
        logic              start;
        logic [PROB_W-1:0] q;
    } t_log_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
    } t_log_rsp;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOG,
        BK_PREP_A,
        BK_DIV_A,
        BK_MUL,
        BK_PREP_L,
        BK_DIV_L,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

// ----- hdl/wbce_front.sv -----
// ----------------------------------------------------------------------------
// wbce_front
// Accepts input items, applies the probability floor and picks the log
// argument for the label, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wbce_front (
    input  wire logic                 i_in_valid,
    input  wbce_pkg::t_in_item        i_in_data,
    input  wire logic [16:0]          i_prob_floor,
    input  wire logic                 i_queue_full,
    output logic                      o_in_stall,
    output logic                      o_push,
    output wbce_pkg::t_queue_item     o_item
);
    import wbce_pkg::*;

    logic [PROB_W-1:0] floored;
    logic [PROB_W-1:0] clipped;
    logic [PROB_W-1:0] arg;

    // Floor, clip to one, and take p or 1-p by label
    always_comb begin
        floored = (i_in_data.probability < i_prob_floor) ? i_prob_floor
                                                         : i_in_data.probability;
        clipped = (floored > ONE_Q16) ? ONE_Q16 : floored;
        arg     = i_in_data.target_bit ? clipped : (ONE_Q16 - clipped);
        o_item.log_zero   = (arg == '0);
        o_item.q          = (arg == '0) ? PROB_W'(1) : arg;
        o_item.target_bit = i_in_data.target_bit;
        o_item.final_item = i_in_data.final_item;
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid & ~i_queue_full;

endmodule

`default_nettype wire

// ----- hdl/wbce_queue.sv -----
// ----------------------------------------------------------------------------
// wbce_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wbce_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wbce_pkg::t_queue_item     i_item,
    input  wire logic                 i_pop,
    output wbce_pkg::t_queue_item     o_item,
    output logic                      o_full,
    output logic                      o_empty
);
    import wbce_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_queue_item       r_mem [QUEUE_DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;

    assign o_full  = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/wbce_log.sv -----
// ----------------------------------------------------------------------------
// wbce_log
// Iterative -ln(q) unit: normalize, one squaring per fraction bit of log2,
// then scale by ln2 with round half up. Result in Q.16.
// ----------------------------------------------------------------------------
`default_nettype none

module wbce_log #(
    parameter int LOG_TABLE_BITS = wbce_pkg::LOG_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wbce_pkg::t_log_req  i_req,
    output wbce_pkg::t_log_rsp  o_rsp
);
    import wbce_pkg::*;

    localparam int CW = $clog2(LOG_TABLE_BITS + 1);

    logic                      r_busy;
    logic                      r_fin;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [PROB_W-1:0]         r_x;
    logic [4:0]                r_s;
    logic [LOG_TABLE_BITS-1:0] r_frac;
    logic [MAG_W-1:0]          r_mag;

    logic [4:0]        msb;
    logic [4:0]        norm_s;
    logic [PROB_W-1:0] norm_x;
    logic [33:0]       sq;
    logic [17:0]       sq_sh;
    logic [MAG_W-1:0]  l2;
    logic [36:0]       scaled;

    // Leading-one position sets the normalizing shift
    always_comb begin
        msb = '0;
        for (int i = 0; i < PROB_W; i++) begin
            if (i_req.q[i]) begin
                msb = 5'(i);
            end
        end
        norm_s = 5'd16 - msb;
        norm_x = i_req.q << norm_s;
    end

    // One squaring step and the final scale
    always_comb begin
        sq     = 34'(r_x) * 34'(r_x);
        sq_sh  = sq[33:16];
        l2     = {r_s, 16'h0000} - (MAG_W'(r_frac) << (16 - LOG_TABLE_BITS));
        scaled = 37'(l2) * 37'(LN2_Q16) + 37'd32768;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(LOG_TABLE_BITS - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= norm_x;
            r_s    <= norm_s;
            r_frac <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_frac <= {r_frac[LOG_TABLE_BITS-2:0], sq_sh[17]};
            r_x    <= sq_sh[17] ? sq_sh[17:1] : sq_sh[16:0];
            r_cnt  <= r_cnt + CW'(1);
        end
        if (r_fin) begin
            r_mag <= scaled[36:16];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.mag  = r_mag;

endmodule

`default_nettype wire

// ----- hdl/wbce_back.sv -----
// ----------------------------------------------------------------------------
// wbce_back
// Pops classified items, runs the log unit, keeps the split sums and counts,
// and on a final item works out alpha, the weighted sum and the loss.
// ----------------------------------------------------------------------------
`default_nettype none

module wbce_back #(
    parameter int COUNT_BITS = wbce_pkg::COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wbce_pkg::t_queue_item     i_q_item,
    input  wire logic                 i_q_empty,
    output logic                      o_pop,
    output wbce_pkg::t_log_req        o_log_req,
    input  wbce_pkg::t_log_rsp        i_log_rsp,
    input  wire logic                 i_balance,
    input  wire logic [15:0]          i_batch,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output wbce_pkg::t_out_item       o_out_data
);
    import wbce_pkg::*;

    // Shared serial divider sizes
    localparam int DVW = (COUNT_BITS + 16 > SUM_W + 1) ? COUNT_BITS + 16 : SUM_W + 1;
    localparam int DSW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int DCW = $clog2(DVW);

    t_back_state           r_state;
    t_back_state           n_state;
    logic                  r_final;
    logic                  r_target;
    logic [SUM_W-1:0]      r_pos_sum;
    logic [SUM_W-1:0]      r_neg_sum;
    logic [COUNT_BITS-1:0] r_pos_cnt;
    logic [COUNT_BITS-1:0] r_tot_cnt;
    logic                  r_clamp;
    logic [PROB_W-1:0]     r_alpha;
    logic [2:0]            r_step;
    logic [44:0]           r_prod;
    logic [72:0]           r_part;
    logic [SUM_W:0]        r_wsum;
    logic [DSW-1:0]        r_rem;
    logic [DSW-1:0]        r_dsr;
    logic [DVW-1:0]        r_dvd;
    logic [DCW-1:0]        r_dcnt;
    t_out_item             r_res;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic                  out_free;
    logic                  pop;
    logic                  acc_en;
    logic                  emit_load;
    logic                  div_last;
    logic [SUM_W:0]        sum_add;
    logic [SUM_W-1:0]      n_pos_sum;
    logic [SUM_W-1:0]      n_neg_sum;
    logic [COUNT_BITS:0]   pos_inc;
    logic [COUNT_BITS:0]   tot_inc;
    logic                  sum_sat;
    logic [DSW:0]          rem2;
    logic                  ge;
    logic [DSW-1:0]        rem_n;
    logic [DVW-1:0]        quo_n;
    logic [PROB_W-1:0]     mul_w;
    logic [27:0]           mul_s;
    logic [72:0]           fold;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:   if (!i_q_empty) n_state = BK_LOG;
            BK_LOG:    if (i_log_rsp.done) n_state = r_final ? BK_PREP_A : BK_IDLE;
            BK_PREP_A: n_state = BK_DIV_A;
            BK_DIV_A:  if (div_last) n_state = BK_MUL;
            BK_MUL:    if (r_step == 3'd4) n_state = BK_PREP_L;
            BK_PREP_L: n_state = BK_DIV_L;
            BK_DIV_L:  if (div_last) n_state = BK_EMIT;
            BK_EMIT:   if (out_free) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        out_free  = ~r_out_valid | ~i_out_stall;
        pop       = (r_state == BK_IDLE) & ~i_q_empty;
        acc_en    = (r_state == BK_LOG) & i_log_rsp.done;
        emit_load = (r_state == BK_EMIT) & out_free;
        div_last  = (r_dcnt == DCW'(DVW - 1));
        o_pop           = pop;
        o_log_req.start = pop;
        o_log_req.q     = i_q_item.q;
    end

    // Saturating sums and counts
    always_comb begin
        sum_add   = {1'b0, r_target ? r_pos_sum : r_neg_sum} + (SUM_W+1)'(i_log_rsp.mag);
        sum_sat   = sum_add[SUM_W];
        n_pos_sum = r_pos_sum;
        n_neg_sum = r_neg_sum;
        if (r_target) begin
            n_pos_sum = sum_sat ? '1 : sum_add[SUM_W-1:0];
        end else begin
            n_neg_sum = sum_sat ? '1 : sum_add[SUM_W-1:0];
        end
        pos_inc = {1'b0, r_pos_cnt} + (COUNT_BITS+1)'(1);
        tot_inc = {1'b0, r_tot_cnt} + (COUNT_BITS+1)'(1);
    end

    // Divider step, multiplier operands and partial-product fold
    always_comb begin
        rem2  = {r_rem, r_dvd[DVW-1]};
        ge    = (rem2 >= {1'b0, r_dsr});
        rem_n = ge ? DSW'(rem2 - {1'b0, r_dsr}) : rem2[DSW-1:0];
        quo_n = {r_dvd[DVW-2:0], ge};
        mul_w = (r_step < 3'd2) ? (ONE_Q16 - r_alpha) : r_alpha;
        case (r_step)
            3'd0:    mul_s = r_pos_sum[55:28];
            3'd1:    mul_s = r_pos_sum[27:0];
            3'd2:    mul_s = r_neg_sum[55:28];
            default: mul_s = r_neg_sum[27:0];
        endcase
        fold = (r_part + 73'(r_prod)) >> 16;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Accumulated state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_sum <= '0;
            r_neg_sum <= '0;
            r_pos_cnt <= '0;
            r_tot_cnt <= '0;
            r_clamp   <= 1'b0;
        end else if (emit_load) begin
            r_pos_sum <= '0;
            r_neg_sum <= '0;
            r_pos_cnt <= '0;
            r_tot_cnt <= '0;
            r_clamp   <= 1'b0;
        end else if (pop) begin
            if (i_q_item.log_zero) r_clamp <= 1'b1;
        end else if (acc_en) begin
            r_pos_sum <= n_pos_sum;
            r_neg_sum <= n_neg_sum;
            if (r_target) begin
                r_pos_cnt <= pos_inc[COUNT_BITS] ? '1 : pos_inc[COUNT_BITS-1:0];
            end
            r_tot_cnt <= tot_inc[COUNT_BITS] ? '1 : tot_inc[COUNT_BITS-1:0];
            if (sum_sat || tot_inc[COUNT_BITS] || (r_target && pos_inc[COUNT_BITS])) begin
                r_clamp <= 1'b1;
            end
        end
    end

    // Finishing datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (pop) begin
                    r_target <= i_q_item.target_bit;
                    r_final  <= i_q_item.final_item;
                end
            end
            BK_PREP_A: begin
                r_rem  <= '0;
                r_dvd  <= DVW'({r_pos_cnt, 16'h0000});
                r_dsr  <= DSW'(r_tot_cnt);
                r_dcnt <= '0;
            end
            BK_DIV_A: begin
                r_rem  <= rem_n;
                r_dvd  <= quo_n;
                r_dcnt <= r_dcnt + DCW'(1);
                r_step <= '0;
                if (div_last) begin
                    r_alpha <= (i_balance && r_tot_cnt != '0) ? quo_n[PROB_W-1:0] : HALF_Q16;
                end
            end
            BK_MUL: begin
                r_prod <= 45'(mul_w) * 45'(mul_s);
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd1:    r_part <= 73'(r_prod) << 28;
                    3'd2:    r_wsum <= fold[SUM_W:0];
                    3'd3:    r_part <= 73'(r_prod) << 28;
                    3'd4:    r_wsum <= r_wsum + fold[SUM_W:0];
                    default: r_part <= '0;
                endcase
            end
            BK_PREP_L: begin
                r_rem  <= '0;
                r_dvd  <= DVW'(r_wsum);
                r_dsr  <= (i_batch == '0) ? DSW'(1) : DSW'(i_batch);
                r_dcnt <= '0;
            end
            BK_DIV_L: begin
                r_rem  <= rem_n;
                r_dvd  <= quo_n;
                r_dcnt <= r_dcnt + DCW'(1);
                if (div_last) begin
                    if (|quo_n[DVW-1:LOSS_W]) begin
                        r_res.loss_value <= '1;
                        r_res.saturated  <= 1'b1;
                    end else begin
                        r_res.loss_value <= quo_n[LOSS_W-1:0];
                        r_res.saturated  <= r_clamp;
                    end
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // Log results only arrive while an item waits for them
    a_log_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_log_rsp.done |-> r_state == BK_LOG)
        else $error("log result outside of log wait");

    // Emitting a result clears the batch state
    a_clear_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |=> (r_tot_cnt == '0 && r_pos_sum == '0 && !r_clamp))
        else $error("batch state not cleared after result");

    // Alpha is a weight of at most one
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_MUL |-> r_alpha <= ONE_Q16)
        else $error("alpha above one");

    // A result transfer always follows from an emit
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == BK_EMIT)
        else $error("output valid without emit");
`endif

endmodule

`default_nettype wire

// ----- hdl/weighted_bce_loss_accumulate_top.sv -----
// ----------------------------------------------------------------------------
// weighted_bce_loss_accumulate_top
// Class-balanced binary cross-entropy loss accumulator with register port.
//
//   channel   direction  handshake               payload
//   input     in         i_in_valid/o_in_stall   i_in_data (t_in_item)
//   result    out        o_out_valid/i_out_stall o_out_data (t_out_item)
//   config    in         psel/penable/pready     paddr, pwdata, prdata
//
// A non-final item's time in the back end is set by the serial squaring
// loop of the log unit. A final item adds the two serial divisions (alpha
// and loss), the five-step partial-product multiply and the setup and emit
// steps, plus any wait of the result register on a stall.
// Reset is synchronous, active low; no clearing pass is needed.
// The four-entry queue keeps accepting until it is full while the back end
// or the result register is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_bce_loss_accumulate_top #(
    parameter int COUNT_BITS     = wbce_pkg::COUNT_BITS_DEF,
    parameter int LOG_TABLE_BITS = wbce_pkg::LOG_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wbce_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output wbce_pkg::t_out_item              o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wbce_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import wbce_pkg::*;

    logic        r_balance;
    logic [15:0] r_batch;
    logic [16:0] r_floor;

    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_queue_item front_item;
    t_queue_item q_item;
    t_log_req    log_req;
    t_log_rsp    log_rsp;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_balance <= 1'b0;
            r_batch   <= 16'd1;
            r_floor   <= 17'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_BALANCE: r_balance <= pwdata[0];
                REG_BATCH:   r_batch   <= pwdata[15:0];
                REG_FLOOR:   r_floor   <= pwdata[16:0];
                default:     r_balance <= r_balance;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_BALANCE: prdata = {31'd0, r_balance};
            REG_BATCH:   prdata = {16'd0, r_batch};
            REG_FLOOR:   prdata = {15'd0, r_floor};
            default:     prdata = '0;
        endcase
    end

    wbce_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_prob_floor (r_floor),
        .i_queue_full (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_item       (front_item)
    );

    wbce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    wbce_log #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (log_req),
        .o_rsp   (log_rsp)
    );

    wbce_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_item    (q_item),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_log_req   (log_req),
        .i_log_rsp   (log_rsp),
        .i_balance   (r_balance),
        .i_batch     (r_batch),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
